// File: design/first_fit_header_allocator_assert.svh
`ifndef FIRST_FIT_HEADER_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEADER_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define FFHA_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("first fit allocator check failed");

// next-cycle implication, off during reset
`define FFHA_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("first fit allocator check failed");

// what must hold in the cycle after reset
`define FFHA_ASSERT_RESET(label, cons) \
label: assert property (@(posedge clock) reset |=> (cons)) \
   else $error("first fit allocator check failed after reset");

`endif

// File: design/ffha_pkg.sv
package ffha_pkg;

   localparam int HEAP_WORDS = 4096;
   localparam int IDX_W      = $clog2(HEAP_WORDS);
   localparam int CNT_W      = $clog2(HEAP_WORDS);
   localparam int WORD_W     = CNT_W + 1;
   localparam int DATA_W     = 32;
   localparam int NEED_W     = DATA_W - 1;

   typedef struct packed {
      logic             used;
      logic [CNT_W-1:0] count;
   } header_type;

   localparam header_type RESET_HEADER = '{used: 1'b0, count: CNT_W'(HEAP_WORDS - 1)};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_MARK,
      ST_SPLIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      header_type        wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } ram_cmd_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] alloc_address;
      logic              granted;
   } result_type;

endpackage

// File: design/ffha_channels.sv
interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] request_bytes;

   modport source (output valid, output request_bytes, input ready);
   modport sink (input valid, input request_bytes, output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] alloc_address;
   logic        granted;

   modport source (output valid, output alloc_address, output granted, input ready);
   modport sink (input valid, input alloc_address, input granted, output ready);
endinterface

interface ffha_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/ffha_ram.sv
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ffha_ctrl.sv
module ffha_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   ffha_req_if.sink                   req_chan,
   ffha_csr_if.sink                   csr_chan,
   input  logic [ffha_pkg::WORD_W-1:0] ram_rd_data,
   output ffha_pkg::ram_cmd_type      ram_cmd,
   input  logic                       slot_free,
   output ffha_pkg::result_type       result
);

   localparam int IW = ffha_pkg::IDX_W;
   localparam int CW = ffha_pkg::CNT_W;

   ffha_pkg::state_type state_ff, state_in;

   logic [IW-1:0]                 idx_ff, idx_in;
   logic [CW-1:0]                 need_ff, need_in;
   logic [CW-1:0]                 old_ff, old_in;
   logic [ffha_pkg::DATA_W-1:0]   res_addr_ff, res_addr_in;
   logic                          res_grant_ff, res_grant_in;
   logic                          w0_ff, w0_in;
   logic [ffha_pkg::DATA_W-1:0]   base_ff, base_in;

   logic                          accept;
   logic [ffha_pkg::NEED_W-1:0]   need_full;
   logic                          trivial_fail;
   ffha_pkg::header_type          hdr;
   logic                          fits;
   logic [IW:0]                   nxt;
   logic                          overrun;
   logic [IW:0]                   rest;
   logic                          rest_ok;
   logic [IW:0]                   idx_p1;
   logic [ffha_pkg::DATA_W-1:0]   alloc_addr;

   assign accept    = req_chan.valid && req_chan.ready;
   assign need_full = {1'b0, req_chan.request_bytes[31:2]}
                    + ffha_pkg::NEED_W'(req_chan.request_bytes[1:0] != 2'b00);
   assign trivial_fail = (req_chan.request_bytes == '0)
                       || (need_full >= ffha_pkg::NEED_W'(ffha_pkg::HEAP_WORDS));

   // word 0 reads as the reset header until it is first rewritten
   assign hdr = (idx_ff == '0 && !w0_ff) ? ffha_pkg::RESET_HEADER
                                         : ffha_pkg::header_type'(ram_rd_data);
   assign fits    = !hdr.used && (hdr.count >= need_ff);
   assign nxt     = {1'b0, idx_ff} + {1'b0, hdr.count} + (IW+1)'(1);
   assign overrun = nxt >= (IW+1)'(ffha_pkg::HEAP_WORDS);
   assign rest    = {1'b0, idx_ff} + {1'b0, need_ff} + (IW+1)'(1);
   assign rest_ok = (old_ff > need_ff) && (rest < (IW+1)'(ffha_pkg::HEAP_WORDS));
   assign idx_p1  = {1'b0, idx_ff} + (IW+1)'(1);
   assign alloc_addr = base_ff
                     + {{(ffha_pkg::DATA_W-IW-3){1'b0}}, idx_p1, 2'b00};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffha_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = trivial_fail ? ffha_pkg::ST_FINISH : ffha_pkg::ST_WALK;
            end
         end
         ffha_pkg::ST_WALK: begin
            if (fits) begin
               state_in = ffha_pkg::ST_MARK;
            end else if (overrun) begin
               state_in = ffha_pkg::ST_FINISH;
            end
         end
         ffha_pkg::ST_MARK: begin
            state_in = rest_ok ? ffha_pkg::ST_SPLIT : ffha_pkg::ST_FINISH;
         end
         ffha_pkg::ST_SPLIT: begin
            state_in = ffha_pkg::ST_FINISH;
         end
         ffha_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = ffha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      csr_chan.ready = !reset;
      ram_cmd        = '0;
      result.valid         = 1'b0;
      result.alloc_address = res_addr_ff;
      result.granted       = res_grant_ff;
      case (state_ff)
         ffha_pkg::ST_IDLE: begin
            req_chan.ready  = !reset;
            ram_cmd.rd_en   = accept && !trivial_fail;
            ram_cmd.rd_addr = '0;
         end
         ffha_pkg::ST_WALK: begin
            ram_cmd.rd_en   = !fits && !overrun;
            ram_cmd.rd_addr = nxt[IW-1:0];
         end
         ffha_pkg::ST_MARK: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = idx_ff;
            ram_cmd.wr_data = '{used: 1'b1, count: need_ff};
         end
         ffha_pkg::ST_SPLIT: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = rest[IW-1:0];
            ram_cmd.wr_data = '{used: 1'b0, count: old_ff - need_ff - CW'(1)};
         end
         ffha_pkg::ST_FINISH: begin
            result.valid = slot_free;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      idx_in       = idx_ff;
      need_in      = need_ff;
      old_in       = old_ff;
      res_addr_in  = res_addr_ff;
      res_grant_in = res_grant_ff;
      w0_in        = w0_ff;
      base_in      = base_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         base_in = {csr_chan.data[31:2], 2'b00};
      end
      case (state_ff)
         ffha_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in       = '0;
               need_in      = need_full[CW-1:0];
               res_addr_in  = '0;
               res_grant_in = 1'b0;
            end
         end
         ffha_pkg::ST_WALK: begin
            if (fits) begin
               old_in = hdr.count;
            end else begin
               idx_in = nxt[IW-1:0];
            end
         end
         ffha_pkg::ST_MARK: begin
            res_addr_in  = alloc_addr;
            res_grant_in = 1'b1;
            if (idx_ff == '0) begin
               w0_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::ST_IDLE;
         w0_ff    <= 1'b0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         w0_ff    <= w0_in;
         base_ff  <= base_in;
      end
      idx_ff       <= idx_in;
      need_ff      <= need_in;
      old_ff       <= old_in;
      res_addr_ff  <= res_addr_in;
      res_grant_ff <= res_grant_in;
   end

endmodule

// File: design/ffha_out.sv
module ffha_out (
   input  logic                 clock,
   input  logic                 reset,
   input  ffha_pkg::result_type result,
   output logic                 slot_free,
   ffha_rsp_if.source           rsp_chan
);

   logic                        valid_ff, valid_in;
   logic [ffha_pkg::DATA_W-1:0] addr_ff, addr_in;
   logic                        grant_ff, grant_in;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      grant_in = grant_ff;
      if (result.valid) begin
         valid_in = 1'b1;
         addr_in  = result.alloc_address;
         grant_in = result.granted;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      addr_ff  <= addr_in;
      grant_ff <= grant_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.alloc_address = addr_ff;
   assign rsp_chan.granted       = grant_ff;

endmodule

// File: design/first_fit_header_allocator.sv
// a zero or oversized request goes from idle straight to the result register; otherwise the header
//    walk visits headers, then writes headers (none on no fit, else 1 or 2) before the result is
//    offered, which waits while the result register stays full; one request in flight at a time
// throughput is set by the header walk: one heap ram read per header, up to 4096 headers
// reset: heap_base cleared, heap seen as one free block; word 0 reads as that block until
//    first rewritten, other words are only read after being written, so no clearing pass
module first_fit_header_allocator (
   input  logic       clock,
   input  logic       reset,
   ffha_req_if.sink   req_chan,
   ffha_rsp_if.source rsp_chan,
   ffha_csr_if.sink   csr_chan
);

   ffha_pkg::ram_cmd_type           ram_cmd;
   logic [ffha_pkg::WORD_W-1:0]     ram_rd_data;
   ffha_pkg::result_type            result;
   logic                            slot_free;

   ffha_ram #(
      .WIDTH (ffha_pkg::WORD_W),
      .DEPTH (ffha_pkg::HEAP_WORDS)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_data)
   );

   ffha_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_chan    (csr_chan),
      .ram_rd_data (ram_rd_data),
      .ram_cmd     (ram_cmd),
      .slot_free   (slot_free),
      .result      (result)
   );

   ffha_out u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: design/ffha_checker.sv
`include "first_fit_header_allocator_assert.svh"

module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_alloc_address,
   input logic        rsp_granted
);

   // a stalled result transaction holds its payload
   `FFHA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_alloc_address) && $stable(rsp_granted))

   // a failed allocation reports address zero
   `FFHA_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_granted, rsp_alloc_address == 32'd0)

   // one request at a time: ready drops right after a request transaction
   `FFHA_ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready)

   // no result left over after reset
   `FFHA_ASSERT_RESET(a_reset_empty, !rsp_valid)

endmodule

bind first_fit_header_allocator ffha_checker u_ffha_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_alloc_address (rsp_chan.alloc_address),
   .rsp_granted       (rsp_chan.granted)
);

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_AT     = 90;

   typedef struct packed {
      logic        in_use;
      logic [30:0] slices;
   } heap_header_type;

   typedef struct packed {
      logic [31:0] alloc_address;
      logic        granted;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset;

   ffha_req_if req_chan ();
   ffha_rsp_if rsp_chan ();
   ffha_csr_if csr_chan ();

   first_fit_header_allocator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // shadow of the heap and of the base register
   heap_header_type  heap_image [ffha_pkg::HEAP_WORDS];
   logic [31:0]      heap_base_image;

   logic [31:0]      pending_requests [$];
   alloc_result_type expected_grants [$];

   logic steady_mode = 1'b0;
   int   mismatch_count = 0;
   int   req_gap;
   int   rsp_gap;
   int   hold_left;
   int   results_seen;
   int   quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_mode)
         return 0;
      else if (roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 96)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_request_bytes();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         return 32'd0;
      else if (roll < 12)
         return $urandom;
      else if (roll < 14)
         return $urandom_range(65, 600);
      else
         return $urandom_range(1, 48);
   endfunction

   // first-fit walk over the shadow heap, updates it on a grant
   function automatic alloc_result_type allocate_first_fit(input logic [31:0] bytes);
      alloc_result_type res;
      longint unsigned  need;
      longint unsigned  idx;
      longint unsigned  old_slices;
      bit               found;
      res   = '{alloc_address: 32'd0, granted: 1'b0};
      need  = bytes >> 2;
      idx   = 0;
      found = 1'b0;
      if (bytes[1:0] != 2'b00)
         need = need + 1;
      if (bytes != 32'd0) begin
         while (idx < ffha_pkg::HEAP_WORDS && !found) begin
            if (!heap_image[idx].in_use && heap_image[idx].slices >= need)
               found = 1'b1;
            else
               idx = idx + heap_image[idx].slices + 1;
         end
      end
      if (found) begin
         old_slices = heap_image[idx].slices;
         heap_image[idx] = '{in_use: 1'b1, slices: 31'(need)};
         if (old_slices > need && idx + 1 + need < ffha_pkg::HEAP_WORDS)
            heap_image[idx + 1 + need] = '{in_use: 1'b0, slices: 31'(old_slices - need - 1)};
         res.alloc_address = heap_base_image + 32'(4 * (idx + 1));
         res.granted       = 1'b1;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic write_heap_base(input logic [31:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      heap_base_image = value & 32'hFFFF_FFFC;
      csr_chan.valid <= 1'b0;
   endtask

   // clean edges in a row (nothing pending, offered or expected), so a transaction launched at the first one is seen
   task automatic wait_drained();
      int clean_edges;
      clean_edges = 0;
      while (clean_edges < 2) begin
         @(posedge clock);
         if (pending_requests.size() != 0 || req_chan.valid || expected_grants.size() != 0)
            clean_edges = 0;
         else
            clean_edges++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid         <= 1'b0;
         req_chan.request_bytes <= 32'd0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_grants.push_back(allocate_first_fit(req_chan.request_bytes));
         if (req_chan.valid && !req_chan.ready) begin
            // keep offering the same transaction
         end else if (req_gap > 0) begin
            req_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_chan.valid         <= 1'b1;
            req_chan.request_bytes <= pending_requests.pop_front();
            req_gap = pick_idle_cycles();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : response_monitor
      alloc_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap      = 0;
         hold_left    = 0;
         results_seen = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_grants.size() == 0) begin
               report_mismatch("transaction with nothing expected", rsp_chan.alloc_address,
                               32'd0);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_chan.alloc_address !== want.alloc_address)
                  report_mismatch("alloc_address", rsp_chan.alloc_address, want.alloc_address);
               if (rsp_chan.granted !== want.granted)
                  report_mismatch("granted", 32'(rsp_chan.granted), 32'(want.granted));
            end
            results_seen++;
            rsp_gap = pick_idle_cycles();
            if (results_seen == LONG_HOLD_AT)
               hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL first_fit_header_allocator");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int walk_idx;
      int tail_slices;
      reset                  <= 1'b1;
      csr_chan.valid         <= 1'b0;
      csr_chan.data          <= 32'd0;
      for (int i = 0; i < ffha_pkg::HEAP_WORDS; i++)
         heap_image[i] = '{in_use: 1'b0, slices: 31'd0};
      heap_image[0]   = '{in_use: 1'b0, slices: 31'(ffha_pkg::HEAP_WORDS - 1)};
      heap_base_image = 32'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // low bits dropped, first block at word 0 wraps to address 0
      write_heap_base(32'hFFFF_FFFF);
      pending_requests = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd8,
                           32'd16381, 32'd16384, 32'hFFFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFD, 32'hFFFF_FFFC, 32'd64, 32'd100, 32'd0,
                           32'd12, 32'd255, 32'd1000};
      wait_drained();

      write_heap_base(32'h0000_0000);
      steady_mode <= 1'b1;
      repeat (40) pending_requests.push_back(pick_request_bytes());
      wait_drained();
      steady_mode <= 1'b0;
      repeat (100) pending_requests.push_back(pick_request_bytes());
      wait_drained();

      write_heap_base($urandom);
      repeat (130) pending_requests.push_back(pick_request_bytes());
      wait_drained();

      // use up the free tail, leaving a zero slice free header where possible
      write_heap_base(32'h0000_0003);
      walk_idx    = 0;
      tail_slices = 0;
      while (walk_idx < ffha_pkg::HEAP_WORDS) begin
         if (!heap_image[walk_idx].in_use)
            tail_slices = heap_image[walk_idx].slices;
         walk_idx = walk_idx + heap_image[walk_idx].slices + 1;
      end
      pending_requests.push_back(32'(tail_slices * 4 + 1));
      if (tail_slices >= 2)
         pending_requests.push_back(32'((tail_slices - 1) * 4 - 2));
      else if (tail_slices == 1)
         pending_requests.push_back(32'd4);
      pending_requests.push_back(32'd1);
      wait_drained();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS first_fit_header_allocator");
      else
         $display("FAIL first_fit_header_allocator");
      $finish;
   end

endmodule
